@@ design/rfla_pkg.sv @@
`timescale 1ns / 1ps

package rfla_pkg;

  localparam int COORD_BITS     = 14;
  localparam int SIZE_BITS      = COORD_BITS + 1;
  localparam int STAMP_BITS     = 32;
  localparam int AREA_BITS      = 2 * SIZE_BITS;
  localparam int FREE_SLOTS_DEF = 64;

  localparam logic [SIZE_BITS-1:0] ATLAS_RESET = SIZE_BITS'(1024);

  // config register indexes
  localparam logic [0:0] CFG_ATLAS_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_ATLAS_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_NO_FIT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TRIM
  } state_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [SIZE_BITS-1:0]  req_width;
    logic [SIZE_BITS-1:0]  req_height;
    logic [COORD_BITS-1:0] free_x;
    logic [COORD_BITS-1:0] free_y;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [COORD_BITS-1:0] place_x;
    logic [COORD_BITS-1:0] place_y;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
  } rect_t;

  typedef struct packed {
    rect_t                 rect;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  // table write-side control
  typedef struct packed {
    logic wr;       // write entry, mark valid
    logic clr_one;  // drop entry at write address
    logic clr_all;  // drop all entries (a same-cycle write still lands)
  } tbl_op_t;

endpackage

@@ design/rfla_table.sv @@
`timescale 1ns / 1ps

module rfla_table import rfla_pkg::*; #(
  parameter int SLOTS    = FREE_SLOTS_DEF,
  parameter int IDX_BITS = $clog2(FREE_SLOTS_DEF)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IDX_BITS-1:0] rd_addr,
  output entry_t              rd_data,
  output logic                rd_valid,
  input  tbl_op_t             op,
  input  logic [IDX_BITS-1:0] wr_addr,
  input  entry_t              wr_data
);

  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      for (int i = 0; i < SLOTS; i++) begin
        if (op.clr_all) begin
          valid[i] <= op.wr && (wr_addr == IDX_BITS'(i));
        end else if (wr_addr == IDX_BITS'(i)) begin
          if (op.wr) begin
            valid[i] <= 1'b1;
          end else if (op.clr_one) begin
            valid[i] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

@@ design/rfla_fit.sv @@
`timescale 1ns / 1ps

module rfla_fit import rfla_pkg::*; #(
  parameter int IDX_BITS = $clog2(FREE_SLOTS_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 in_vld,
  input  entry_t               in_entry,
  input  logic [IDX_BITS-1:0]  in_idx,
  input  logic [SIZE_BITS-1:0] need_w,
  input  logic [SIZE_BITS-1:0] need_h,
  output logic                 best_found,
  output logic [IDX_BITS-1:0]  best_idx,
  output entry_t               best
);

  // stage A: fit test and area product
  logic                 a_vld;
  logic [AREA_BITS-1:0] a_area;
  entry_t               a_entry;
  logic [IDX_BITS-1:0]  a_idx;
  logic                 fits;

  // stage B: running best
  logic [AREA_BITS-1:0] best_area;
  logic                 better;

  assign fits = in_vld && (in_entry.rect.w >= need_w) && (in_entry.rect.h >= need_h);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= fits;
    end
  end

  always_ff @(posedge clk) begin
    a_area  <= AREA_BITS'(in_entry.rect.w) * AREA_BITS'(in_entry.rect.h);
    a_entry <= in_entry;
    a_idx   <= in_idx;
  end

  // smaller area wins; on equal area the larger stamp wins
  assign better = !best_found || (a_area < best_area) ||
                  ((a_area == best_area) && (a_entry.stamp > best.stamp));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_found <= 1'b0;
    end else if (a_vld && better) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld && better && !clear) begin
      best_area <= a_area;
      best      <= a_entry;
      best_idx  <= a_idx;
    end
  end

endmodule

@@ design/rect_free_list_allocator_top.sv @@
`timescale 1ns / 1ps
// Sequence: allocate and free of a nonzero size scan every table slot before the decide step, and an
// allocate that splits off a lower strip adds a trim step; clear, zero-size and unused requests go to decide.
// Throughput: one item at a time; busy stays high until the item's result is out, so the
// table scan (one slot per cycle through one memory read port) sets the rate.
// Reset (rst, synchronous): table empty, stamp counter zero, atlas 1024 x 1024.
// The result is shown on result with done, which is high for exactly one cycle; the receiver cannot stall.

module rect_free_list_allocator_top import rfla_pkg::*; #(
  parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  output logic                 done,
  output result_t              result,
  input  logic                 cfg_wr_en,
  input  logic [0:0]           cfg_index,
  input  logic [SIZE_BITS-1:0] cfg_data
);

  localparam int IDX_BITS = $clog2(FREE_SLOTS);
  localparam int CNT_BITS = $clog2(FREE_SLOTS + 2);
  // last scan count: read pipe (memory, area product, best update) drained
  localparam logic [CNT_BITS-1:0] SCAN_LAST = CNT_BITS'(FREE_SLOTS + 1);
  localparam logic [CNT_BITS-1:0] SCAN_END  = CNT_BITS'(FREE_SLOTS);

  state_e state, state_next;

  // request and config
  req_t                  req_q;
  func_e                 func_q;
  logic                  req_nz;
  logic [SIZE_BITS-1:0]  atlas_w;
  logic [SIZE_BITS-1:0]  atlas_h;
  logic [STAMP_BITS-1:0] stamp;

  // scan
  logic [CNT_BITS-1:0] cnt;
  logic                rd_go;
  logic                s1_vld;
  logic [IDX_BITS-1:0] s1_idx;
  logic                empty_found;
  logic [IDX_BITS-1:0] empty_idx;
  logic                accept;
  logic                scan_in;

  // table
  entry_t              rd_data;
  logic                rd_valid;
  tbl_op_t             tbl_op;
  logic [IDX_BITS-1:0] wr_addr;
  entry_t              wr_data;

  // best fit
  logic                best_found;
  logic [IDX_BITS-1:0] best_idx;
  entry_t              best;
  logic                wider, taller, exact, split_go;

  // candidate table entries
  entry_t trim_x_e, trim_y_e, strip_e, free_e, clear_e;

  // result
  logic    res_load;
  result_t res_next;
  logic    done_set;
  logic    stamp_inc;

  assign func_q  = func_e'(req_q.func);
  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  // only allocate/free of a nonzero size need the slot scan
  assign scan_in = ((req.func == FUNC_ALLOC) || (req.func == FUNC_FREE)) &&
                   (req.req_width != '0) && (req.req_height != '0);
  assign rd_go   = (state == ST_SCAN) && (cnt < SCAN_END);

  rfla_table #(
    .SLOTS    (FREE_SLOTS),
    .IDX_BITS (IDX_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (cnt[IDX_BITS-1:0]),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .op       (tbl_op),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // single fit/area/compare unit; fed one slot per cycle during an allocate's scan
  rfla_fit #(
    .IDX_BITS (IDX_BITS)
  ) u_fit (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .in_vld     (s1_vld && rd_valid && (func_q == FUNC_ALLOC)),
    .in_entry   (rd_data),
    .in_idx     (s1_idx),
    .need_w     (req_q.req_width),
    .need_h     (req_q.req_height),
    .best_found (best_found),
    .best_idx   (best_idx),
    .best       (best)
  );

  assign wider    = best.rect.w > req_q.req_width;
  assign taller   = best.rect.h > req_q.req_height;
  assign exact    = (best.rect.w == req_q.req_width) && (best.rect.h == req_q.req_height);
  // a two-way guillotine split needs a second slot for the lower strip
  assign split_go = (func_q == FUNC_ALLOC) && best_found && wider && taller && empty_found;

  always_comb begin
    // best trimmed on the left by the allocated columns
    trim_x_e        = best;
    trim_x_e.rect.x = best.rect.x + req_q.req_width[COORD_BITS-1:0];
    trim_x_e.rect.w = best.rect.w - req_q.req_width;
    // best trimmed on top by the allocated rows
    trim_y_e        = best;
    trim_y_e.rect.y = best.rect.y + req_q.req_height[COORD_BITS-1:0];
    trim_y_e.rect.h = best.rect.h - req_q.req_height;
    // strip below the allocation, request wide
    strip_e.rect.x  = best.rect.x;
    strip_e.rect.y  = best.rect.y + req_q.req_height[COORD_BITS-1:0];
    strip_e.rect.w  = req_q.req_width;
    strip_e.rect.h  = best.rect.h - req_q.req_height;
    strip_e.stamp   = stamp;
    // freed rectangle
    free_e.rect.x   = req_q.free_x;
    free_e.rect.y   = req_q.free_y;
    free_e.rect.w   = req_q.req_width;
    free_e.rect.h   = req_q.req_height;
    free_e.stamp    = stamp;
    // whole atlas
    clear_e.rect.x  = '0;
    clear_e.rect.y  = '0;
    clear_e.rect.w  = atlas_w;
    clear_e.rect.h  = atlas_h;
    clear_e.stamp   = stamp;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = scan_in ? ST_SCAN : ST_DECIDE;
        end
      end
      ST_SCAN: begin
        if (cnt == SCAN_LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = split_go ? ST_TRIM : ST_IDLE;
      end
      ST_TRIM: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs: table writes, stamp, result
  always_comb begin
    tbl_op    = '0;
    wr_addr   = best_idx;
    wr_data   = best;
    stamp_inc = 1'b0;
    res_load  = 1'b0;
    res_next  = '0;
    done_set  = 1'b0;
    case (state)
      ST_DECIDE: begin
        res_load = 1'b1;
        done_set = !split_go;
        case (func_q)
          FUNC_ALLOC: begin
            if (!best_found) begin
              res_next.status = STATUS_NO_FIT;
            end else if (wider && taller) begin
              if (!empty_found) begin
                res_next.status = STATUS_FULL;
              end else begin
                res_next.status  = STATUS_OK;
                res_next.place_x = best.rect.x;
                res_next.place_y = best.rect.y;
                tbl_op.wr        = 1'b1;
                wr_addr          = empty_idx;
                wr_data          = strip_e;
                stamp_inc        = 1'b1;
              end
            end else begin
              res_next.status  = STATUS_OK;
              res_next.place_x = best.rect.x;
              res_next.place_y = best.rect.y;
              if (exact) begin
                tbl_op.clr_one = 1'b1;
              end else if (wider) begin
                tbl_op.wr = 1'b1;
                wr_data   = trim_x_e;
              end else begin
                tbl_op.wr = 1'b1;
                wr_data   = trim_y_e;
              end
            end
          end
          FUNC_FREE: begin
            if (req_nz) begin
              if (!empty_found) begin
                res_next.status = STATUS_FULL;
              end else begin
                tbl_op.wr = 1'b1;
                wr_addr   = empty_idx;
                wr_data   = free_e;
                stamp_inc = 1'b1;
              end
            end
          end
          FUNC_CLEAR: begin
            tbl_op.clr_all = 1'b1;
            tbl_op.wr      = 1'b1;
            wr_addr        = '0;
            wr_data        = clear_e;
            stamp_inc      = 1'b1;
          end
          default: begin
            // unused code: ok, no change
          end
        endcase
      end
      ST_TRIM: begin
        // second half of the split: shrink the chosen rectangle
        tbl_op.wr = 1'b1;
        wr_addr   = best_idx;
        wr_data   = trim_x_e;
        done_set  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      stamp       <= '0;
      atlas_w     <= ATLAS_RESET;
      atlas_h     <= ATLAS_RESET;
      s1_vld      <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      state  <= state_next;
      done   <= done_set;
      s1_vld <= rd_go;
      if (stamp_inc) begin
        stamp <= stamp + 1'b1;
      end
      if (cfg_wr_en) begin
        if (cfg_index == CFG_ATLAS_WIDTH) begin
          atlas_w <= cfg_data;
        end
        if (cfg_index == CFG_ATLAS_HEIGHT) begin
          atlas_h <= cfg_data;
        end
      end
      // lowest-numbered free slot, seen in slot order during the scan
      if (accept) begin
        empty_found <= 1'b0;
      end else if (s1_vld && !rd_valid && !empty_found) begin
        empty_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q  <= req;
      req_nz <= (req.req_width != '0) && (req.req_height != '0);
      cnt    <= '0;
    end else if (state == ST_SCAN) begin
      cnt <= cnt + 1'b1;
    end
    s1_idx <= cnt[IDX_BITS-1:0];
    if (s1_vld && !rd_valid && !empty_found) begin
      empty_idx <= s1_idx;
    end
    if (res_load) begin
      result <= res_next;
    end
  end

  // result strobe never lasts more than one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // the trim write always follows a decide that wrote the strip
  a_trim_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TRIM) |-> ($past(state) == ST_DECIDE && $past(tbl_op.wr)))
    else $error("trim without preceding strip insert");

  // table is read-only during the scan
  a_scan_ro: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !(tbl_op.wr || tbl_op.clr_one || tbl_op.clr_all))
    else $error("table write during scan");

  // failed requests report a zero corner
  a_zero_corner: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_OK) |-> (result.place_x == '0 && result.place_y == '0))
    else $error("nonzero corner on failed request");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rfla_pkg::*;

  // func code left unused by the block; it must answer ok with a zero corner
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         RUN_LIMIT_NS = 4_000_000;
  localparam int         DRAIN_LIMIT  = 2000;  // cycles to wait for the last results
  localparam int         SETTLE       = 80;    // about one full table scan

  // Scoreboard: keeps its own copy of the free-rectangle table and atlas size,
  // predicts the placement for every accepted item and checks results in order.
  class atlas_scoreboard;
    rect_t                 table_rect[FREE_SLOTS_DEF];
    bit                    table_used[FREE_SLOTS_DEF];
    logic [STAMP_BITS-1:0] table_stamp[FREE_SLOTS_DEF];
    logic [STAMP_BITS-1:0] stamp_next;
    logic [SIZE_BITS-1:0]  atlas_w;
    logic [SIZE_BITS-1:0]  atlas_h;

    result_t pending_placements[$];
    rect_t   live_allocs[$];      // placed rectangles, handed back by the driver
    int      mismatches;
    int      n_items, n_ok, n_no_fit, n_full, n_frees, n_clears;

    function new();
      for (int i = 0; i < FREE_SLOTS_DEF; i++) begin
        table_used[i] = 1'b0;
      end
      stamp_next = '0;
      atlas_w    = ATLAS_RESET;
      atlas_h    = ATLAS_RESET;
      mismatches = 0;
      n_items = 0; n_ok = 0; n_no_fit = 0; n_full = 0; n_frees = 0; n_clears = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [SIZE_BITS-1:0] data);
      if (idx == CFG_ATLAS_WIDTH) atlas_w = data;
      else                        atlas_h = data;
    endfunction

    function int lowest_free_slot();
      for (int i = 0; i < FREE_SLOTS_DEF; i++) begin
        if (!table_used[i]) return i;
      end
      return -1;
    endfunction

    function void insert_rect(int slot, logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                              logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
      table_rect[slot].x = x;
      table_rect[slot].y = y;
      table_rect[slot].w = w;
      table_rect[slot].h = h;
      table_used[slot]   = 1'b1;
      table_stamp[slot]  = stamp_next;
      stamp_next         = stamp_next + 1;
    endfunction

    function void note_request(req_t item);
      result_t        want;
      rect_t          r;
      rect_t          placed;
      int             best;
      int             slot;
      logic [31:0]    area;
      logic [31:0]    best_area;
      logic [SIZE_BITS-1:0] rw;
      logic [SIZE_BITS-1:0] rh;

      want      = '0;
      rw        = item.req_width;
      rh        = item.req_height;
      best      = -1;
      best_area = '0;
      n_items++;
      case (item.func)
        FUNC_ALLOC: begin
          if (rw != 0 && rh != 0) begin
            for (int i = 0; i < FREE_SLOTS_DEF; i++) begin
              if (table_used[i] && table_rect[i].w >= rw && table_rect[i].h >= rh) begin
                area = 32'(table_rect[i].w) * 32'(table_rect[i].h);
                // smallest area wins; on a tie the larger stamp (newer rect)
                if (best < 0 || area < best_area ||
                    (area == best_area && table_stamp[i] > table_stamp[best])) begin
                  best      = i;
                  best_area = area;
                end
              end
            end
          end
          if (best < 0) begin
            want.status = STATUS_NO_FIT;
          end else begin
            r = table_rect[best];
            if (r.w > rw && r.h > rh) begin
              // needs a lower strip: only if a slot is left
              slot = lowest_free_slot();
              if (slot < 0) begin
                want.status = STATUS_FULL;
              end else begin
                want.place_x = r.x;
                want.place_y = r.y;
                insert_rect(slot, r.x, COORD_BITS'(r.y + rh), rw, r.h - rh);
                table_rect[best].x = COORD_BITS'(r.x + rw);
                table_rect[best].w = r.w - rw;
              end
            end else begin
              want.place_x = r.x;
              want.place_y = r.y;
              if (r.w == rw && r.h == rh) begin
                table_used[best] = 1'b0;
              end else if (r.w > rw) begin
                table_rect[best].x = COORD_BITS'(r.x + rw);
                table_rect[best].w = r.w - rw;
              end else begin
                table_rect[best].y = COORD_BITS'(r.y + rh);
                table_rect[best].h = r.h - rh;
              end
            end
            if (want.status == STATUS_OK) begin
              placed.x = r.x;
              placed.y = r.y;
              placed.w = rw;
              placed.h = rh;
              live_allocs.push_back(placed);
            end
          end
        end
        FUNC_FREE: begin
          n_frees++;
          if (rw != 0 && rh != 0) begin
            slot = lowest_free_slot();
            if (slot < 0) want.status = STATUS_FULL;
            else          insert_rect(slot, item.free_x, item.free_y, rw, rh);
          end
        end
        FUNC_CLEAR: begin
          n_clears++;
          for (int i = 0; i < FREE_SLOTS_DEF; i++) begin
            table_used[i] = 1'b0;
          end
          insert_rect(0, '0, '0, atlas_w, atlas_h);
          live_allocs.delete();
        end
        default: ;
      endcase
      case (want.status)
        STATUS_OK:     n_ok++;
        STATUS_NO_FIT: n_no_fit++;
        default:       n_full++;
      endcase
      pending_placements.push_back(want);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_placements.size() == 0) begin
        report_mismatch($sformatf("result with no item pending (status %0d)", got.status));
      end else begin
        want = pending_placements.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.place_x !== want.place_x)
          report_mismatch($sformatf("place_x %0d, expected %0d", got.place_x, want.place_x));
        if (got.place_y !== want.place_y)
          report_mismatch($sformatf("place_y %0d, expected %0d", got.place_y, want.place_y));
      end
    endtask

    function int pending();
      return pending_placements.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_wr_en = 1'b0;
  logic [0:0]           cfg_index = CFG_ATLAS_WIDTH;
  logic [SIZE_BITS-1:0] cfg_data = '0;

  atlas_scoreboard sb = new();

  int    burst_left = 0;   // items left in the current sender burst
  int    n_settings = 0;
  rect_t recent_frees[$];  // sizes handed back lately; reused to hit exact fits

  always #1 clk = ~clk;

  rect_free_list_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Monitor: everything is sampled at the rising edge, before the block's
  // own updates land. A result can never belong to an item taken at the
  // same edge, so checking first and noting second keeps the order right.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_request(req);
      if (cfg_wr_en) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout: %0d results still pending", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic req_t make_req(logic [1:0] f, logic [SIZE_BITS-1:0] w,
                                    logic [SIZE_BITS-1:0] h, logic [COORD_BITS-1:0] x,
                                    logic [COORD_BITS-1:0] y);
    req_t item;
    item.func       = f;
    item.req_width  = w;
    item.req_height = h;
    item.free_x     = x;
    item.free_y     = y;
    return item;
  endfunction

  // Present one item and hold it until the block takes it. The sender works
  // in bursts; between bursts start drops for a random gap (sometimes none),
  // so new items show up at every point of the scan.
  task automatic send_item(input req_t item);
    int gap;
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Block idle: nothing in flight, nothing pending.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_atlas(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ATLAS_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_ATLAS_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Short hand-picked sequence on the reset atlas (1024 x 1024).
  task automatic directed_items();
    send_item(make_req(FUNC_ALLOC, 10, 10, 0, 0));         // empty table: no fit
    send_item(make_req(FUNC_CLEAR, 0, 0, 0, 0));
    send_item(make_req(FUNC_ALLOC, 0, 10, 0, 0));          // zero width
    send_item(make_req(FUNC_ALLOC, 10, 0, 0, 0));          // zero height
    send_item(make_req(FUNC_ALLOC, 1024, 1024, 0, 0));     // exact fit, slot dropped
    send_item(make_req(FUNC_ALLOC, 1, 1, 0, 0));           // nothing left
    send_item(make_req(FUNC_FREE, 0, 5, 7, 7));            // zero-size free
    send_item(make_req(FUNC_UNUSED, 15'h7fff, 15'h7fff, 14'h3fff, 14'h3fff));
    send_item(make_req(FUNC_FREE, 1024, 1024, 0, 0));
    send_item(make_req(FUNC_ALLOC, 100, 50, 0, 0));        // split on x, lower strip
    send_item(make_req(FUNC_ALLOC, 100, 974, 0, 0));       // takes the strip exactly
    send_item(make_req(FUNC_ALLOC, 924, 100, 0, 0));       // same width: trim on y
    send_item(make_req(FUNC_ALLOC, 15'h7fff, 15'h7fff, 0, 0));
    send_item(make_req(FUNC_FREE, 15'h7fff, 15'h7fff, 14'h3fff, 14'h3fff));
    send_item(make_req(FUNC_ALLOC, 15'h7fff, 15'h7fff, 0, 0));
    send_item(make_req(FUNC_FREE, 5, 5, 14'h3fff, 14'h3fff));
    send_item(make_req(FUNC_ALLOC, 2, 3, 0, 0));           // split wraps x and y
    send_item(make_req(FUNC_FREE, 4, 16, 40, 40));
    send_item(make_req(FUNC_FREE, 16, 4, 80, 80));
    send_item(make_req(FUNC_ALLOC, 4, 4, 0, 0));           // equal areas: newer one
    send_item(make_req(FUNC_FREE, 8, 8, 200, 200));
    send_item(make_req(FUNC_FREE, 8, 8, 300, 300));
    send_item(make_req(FUNC_ALLOC, 8, 8, 0, 0));           // same size tie: newer one
    send_item(make_req(FUNC_ALLOC, 16384, 1, 0, 0));
    send_item(make_req(FUNC_CLEAR, 0, 0, 0, 0));
  endtask

  // One atlas setting: clear, optionally flood the table until it is full,
  // then a random mix. Most items are allocations sized to the atlas and frees
  // of earlier placements; the rest is noise.
  task automatic random_phase(input int n_items, input bit flood,
                              input logic [SIZE_BITS-1:0] aw, input logic [SIZE_BITS-1:0] ah);
    int                   sel;
    int                   idx;
    int                   span_w;
    int                   span_h;
    rect_t                r;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;

    span_w = (aw / 6 > 0) ? aw / 6 : 4;
    span_h = (ah / 6 > 0) ? ah / 6 : 4;
    send_item(make_req(FUNC_CLEAR, 0, 0, 0, 0));
    if (flood) begin
      // more frees than slots: ends in table full on free, then on split
      for (int k = 0; k < 70; k++)
        send_item(make_req(FUNC_FREE, 8, 8, COORD_BITS'($urandom_range(0, 16383)),
                           COORD_BITS'($urandom_range(0, 16383))));
      for (int k = 0; k < 12; k++)
        send_item(make_req(FUNC_ALLOC, SIZE_BITS'($urandom_range(1, 8)),
                           SIZE_BITS'($urandom_range(1, 8)), 0, 0));
    end
    for (int k = 0; k < n_items; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50 || (sel < 78 && sb.live_allocs.size() == 0)) begin
        if (recent_frees.size() != 0 && $urandom_range(0, 2) == 0) begin
          r = recent_frees[$urandom_range(0, recent_frees.size() - 1)];
          w = r.w;
          h = r.h;
        end else begin
          w = SIZE_BITS'($urandom_range(1, span_w));
          h = SIZE_BITS'($urandom_range(1, span_h));
        end
        send_item(make_req(FUNC_ALLOC, w, h, COORD_BITS'($urandom), COORD_BITS'($urandom)));
      end else if (sel < 78) begin
        idx = $urandom_range(0, sb.live_allocs.size() - 1);
        r   = sb.live_allocs[idx];
        sb.live_allocs.delete(idx);
        recent_frees.push_back(r);
        if (recent_frees.size() > 16) void'(recent_frees.pop_front());
        send_item(make_req(FUNC_FREE, r.w, r.h, r.x, r.y));
      end else if (sel < 84) begin
        // stray free anywhere, overlaps allowed
        send_item(make_req(FUNC_FREE, SIZE_BITS'($urandom_range(1, span_w)),
                           SIZE_BITS'($urandom_range(1, span_h)),
                           COORD_BITS'($urandom), COORD_BITS'($urandom)));
      end else if (sel < 90) begin
        send_item(make_req(FUNC_ALLOC, SIZE_BITS'($urandom), SIZE_BITS'($urandom),
                           COORD_BITS'($urandom), COORD_BITS'($urandom)));
      end else if (sel < 94) begin
        w = ($urandom_range(0, 1) == 0) ? '0 : SIZE_BITS'($urandom);
        h = (w == 0) ? SIZE_BITS'($urandom) : '0;
        send_item(make_req($urandom_range(0, 1) ? FUNC_FREE : FUNC_ALLOC, w, h,
                           COORD_BITS'($urandom), COORD_BITS'($urandom)));
      end else if (sel < 97) begin
        send_item(make_req(FUNC_UNUSED, SIZE_BITS'($urandom), SIZE_BITS'($urandom),
                           COORD_BITS'($urandom), COORD_BITS'($urandom)));
      end else begin
        send_item(make_req(FUNC_CLEAR, SIZE_BITS'($urandom), SIZE_BITS'($urandom),
                           COORD_BITS'($urandom), COORD_BITS'($urandom)));
      end
    end
  endtask

  initial begin
    logic [SIZE_BITS-1:0] phase_w[10];
    logic [SIZE_BITS-1:0] phase_h[10];
    int                   waited;

    // extremes first, then a few ordinary and random sizes
    phase_w = '{16384, 1, 0, 15'h7fff, 64, 1024, 0, 300, 0, 0};
    phase_h = '{16384, 1, 0, 15'h7fff, 48, 1024, 300, 0, 0, 0};
    for (int p = 8; p < 10; p++) begin
      phase_w[p] = SIZE_BITS'($urandom_range(1, 16384));
      phase_h[p] = SIZE_BITS'($urandom_range(1, 16384));
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_items();
    for (int p = 0; p < 10; p++) begin
      set_atlas(phase_w[p], phase_h[p]);
      random_phase(140, (p % 2) == 0, phase_w[p], phase_h[p]);
    end

    // drain: every expected result must show up, then nothing more may come
    start <= 1'b0;
    waited = 0;
    while ((sb.pending() != 0 || busy) && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Covered %0d items over %0d atlas settings (%0d frees, %0d clears).",
             sb.n_items, n_settings + 1, sb.n_frees, sb.n_clears);
    $display("Outcomes: %0d ok, %0d no fit, %0d table full; %0d mismatches.",
             sb.n_ok, sb.n_no_fit, sb.n_full, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
